// ===== sv/irpfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfd_pkg
// Shared types, constants and a helper function of the infrared pulse frame
// decoder.
// ----------------------------------------------------------------------------
package irpfd_pkg;

	// Frame geometry.
	localparam int FRAME_PULSES = 18;
	localparam int FIELD_BITS   = 4;
	localparam int IDX_W        = 5;
	localparam int DUR_W        = 16;
	localparam int KIND_W       = 2;
	localparam int REASON_W     = 3;

	// Position after the last channel bit pair.
	localparam logic [IDX_W-1:0] CHAN_END  = IDX_W'(2 + 2 * FIELD_BITS);
	localparam logic [IDX_W-1:0] FRAME_LEN = IDX_W'(FRAME_PULSES);
	localparam logic [IDX_W-1:0] IDX_MAX   = '1;
	localparam logic [IDX_W-1:0] POS_PRE_TOGGLE = IDX_W'(0);
	localparam logic [IDX_W-1:0] POS_PRE_SPACE  = IDX_W'(1);

	// Pulse kinds.
	localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPACE  = 2'd1;

	// Error reasons.
	localparam logic [REASON_W-1:0] ERR_NONE     = 3'd0;
	localparam logic [REASON_W-1:0] ERR_LENGTH   = 3'd1;
	localparam logic [REASON_W-1:0] ERR_KIND     = 3'd2;
	localparam logic [REASON_W-1:0] ERR_PREAMBLE = 3'd3;
	localparam logic [REASON_W-1:0] ERR_CHANNEL  = 3'd4;

	// Configuration register map.
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam logic [2:0] REG_PREAMBLE_MIN = 3'd0;
	localparam logic [2:0] REG_PREAMBLE_MAX = 3'd1;
	localparam logic [2:0] REG_SHORT_MIN    = 3'd2;
	localparam logic [2:0] REG_SHORT_MAX    = 3'd3;
	localparam logic [2:0] REG_LONG_MIN     = 3'd4;
	localparam logic [2:0] REG_LONG_MAX     = 3'd5;
	localparam logic [2:0] REG_CHAN_A       = 3'd6;
	localparam logic [2:0] REG_CHAN_B       = 3'd7;

	// Register reset values.
	localparam logic [DUR_W-1:0]      RST_PREAMBLE_MIN = 16'd5900;
	localparam logic [DUR_W-1:0]      RST_PREAMBLE_MAX = 16'd6100;
	localparam logic [DUR_W-1:0]      RST_SHORT_MIN    = 16'd400;
	localparam logic [DUR_W-1:0]      RST_SHORT_MAX    = 16'd600;
	localparam logic [DUR_W-1:0]      RST_LONG_MIN     = 16'd1400;
	localparam logic [DUR_W-1:0]      RST_LONG_MAX     = 16'd1600;
	localparam logic [FIELD_BITS-1:0] RST_CHAN_A       = 4'd0;
	localparam logic [FIELD_BITS-1:0] RST_CHAN_B       = 4'd1;

	// Configuration as seen by the decoder.
	typedef struct packed {
		logic [DUR_W-1:0]      preamble_min;
		logic [DUR_W-1:0]      preamble_max;
		logic [DUR_W-1:0]      short_min;
		logic [DUR_W-1:0]      short_max;
		logic [DUR_W-1:0]      long_min;
		logic [DUR_W-1:0]      long_max;
		logic [FIELD_BITS-1:0] chan_a;
		logic [FIELD_BITS-1:0] chan_b;
	} cfg_t;

	// True when the value lies strictly between the two bounds.
	function automatic logic in_window(
		input logic [DUR_W-1:0] v,
		input logic [DUR_W-1:0] lo,
		input logic [DUR_W-1:0] hi
	);
		return (v > lo) && (v < hi);
	endfunction

endpackage

// ===== sv/irpfd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfd_if
// Valid/ready channels of the decoder: one for pulses in, one for frame
// results out.
// ----------------------------------------------------------------------------
interface irpfd_pulse_if
	import irpfd_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   pulse_kind;
	logic [DUR_W-1:0]    pulse_duration;
	logic                frame_end;

	modport source (output valid, pulse_kind, pulse_duration, frame_end, input ready);
	modport sink (input valid, pulse_kind, pulse_duration, frame_end, output ready);
endinterface

interface irpfd_result_if
	import irpfd_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic                  frame_ok;
	logic [FIELD_BITS-1:0] channel_code;
	logic [FIELD_BITS-1:0] command_code;
	logic [REASON_W-1:0]   error_reason;

	modport source (output valid, frame_ok, channel_code, command_code, error_reason,
		input ready);
	modport sink (input valid, frame_ok, channel_code, command_code, error_reason,
		output ready);
endinterface

// ===== sv/irpfd_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfd_regs
// APB-style configuration register file holding the duration windows and
// the two accepted channel codes.
// ----------------------------------------------------------------------------
module irpfd_regs
	import irpfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_min <= RST_PREAMBLE_MIN;
			cfg_q.preamble_max <= RST_PREAMBLE_MAX;
			cfg_q.short_min    <= RST_SHORT_MIN;
			cfg_q.short_max    <= RST_SHORT_MAX;
			cfg_q.long_min     <= RST_LONG_MIN;
			cfg_q.long_max     <= RST_LONG_MAX;
			cfg_q.chan_a       <= RST_CHAN_A;
			cfg_q.chan_b       <= RST_CHAN_B;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PREAMBLE_MIN: cfg_q.preamble_min <= pwdata[DUR_W-1:0];
				REG_PREAMBLE_MAX: cfg_q.preamble_max <= pwdata[DUR_W-1:0];
				REG_SHORT_MIN:    cfg_q.short_min    <= pwdata[DUR_W-1:0];
				REG_SHORT_MAX:    cfg_q.short_max    <= pwdata[DUR_W-1:0];
				REG_LONG_MIN:     cfg_q.long_min     <= pwdata[DUR_W-1:0];
				REG_LONG_MAX:     cfg_q.long_max     <= pwdata[DUR_W-1:0];
				REG_CHAN_A:       cfg_q.chan_a       <= pwdata[FIELD_BITS-1:0];
				REG_CHAN_B:       cfg_q.chan_b       <= pwdata[FIELD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero extended.
	always_comb begin
		case (reg_idx)
			REG_PREAMBLE_MIN: prdata = APB_DATA_W'(cfg_q.preamble_min);
			REG_PREAMBLE_MAX: prdata = APB_DATA_W'(cfg_q.preamble_max);
			REG_SHORT_MIN:    prdata = APB_DATA_W'(cfg_q.short_min);
			REG_SHORT_MAX:    prdata = APB_DATA_W'(cfg_q.short_max);
			REG_LONG_MIN:     prdata = APB_DATA_W'(cfg_q.long_min);
			REG_LONG_MAX:     prdata = APB_DATA_W'(cfg_q.long_max);
			REG_CHAN_A:       prdata = APB_DATA_W'(cfg_q.chan_a);
			REG_CHAN_B:       prdata = APB_DATA_W'(cfg_q.chan_b);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== sv/irpfd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfd_decode
// Pulse input register, frame state and result register. Each registered
// pulse updates the frame state as it leaves the input register; the marked
// last pulse clears it and writes one result into the output register.
// ----------------------------------------------------------------------------
module irpfd_decode
	import irpfd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	irpfd_pulse_if.sink  pulse,
	irpfd_result_if.source result
);

	// Input stage.
	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [DUR_W-1:0]  dur_s1;
	logic              last_s1;

	// Frame state.
	logic [IDX_W-1:0]      idx_q;
	logic                  kind_err_q;
	logic                  pre_err_q;
	logic                  tog_long_q;
	logic [FIELD_BITS-1:0] chan_q;
	logic [FIELD_BITS-1:0] cmd_q;

	// Result register.
	logic                  out_valid_q;
	logic                  ok_q;
	logic [FIELD_BITS-1:0] chan_out_q;
	logic [FIELD_BITS-1:0] cmd_out_q;
	logic [REASON_W-1:0]   reason_q;

	// Next-state and result logic.
	logic                  go_s1;
	logic                  in_ready;
	logic                  in_frame;
	logic                  odd;
	logic                  data_pos;
	logic                  bit_val;
	logic [KIND_W-1:0]     kind_exp;
	logic [IDX_W-1:0]      idx_n;
	logic                  kind_err_n;
	logic                  pre_err_n;
	logic                  tog_long_n;
	logic [FIELD_BITS-1:0] chan_n;
	logic [FIELD_BITS-1:0] cmd_n;
	logic [REASON_W-1:0]   reason_n;

	// The stage moves on unless it holds a last pulse and the result is stuck.
	assign go_s1    = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign in_ready = !valid_s1 || go_s1;
	assign pulse.ready = in_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= pulse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && pulse.valid) begin
			kind_s1 <= pulse.pulse_kind;
			dur_s1  <= pulse.pulse_duration;
			last_s1 <= pulse.frame_end;
		end
	end

	// Decode of one pulse against the frame position.
	always_comb begin
		in_frame = idx_q < FRAME_LEN;
		odd      = idx_q[0];
		data_pos = in_frame && (idx_q != POS_PRE_TOGGLE) && (idx_q != POS_PRE_SPACE);
		kind_exp = odd ? KIND_SPACE : KIND_TOGGLE;
		bit_val  = tog_long_q && (dur_s1 > cfg.short_min);

		kind_err_n = kind_err_q || (in_frame && (kind_s1 != kind_exp));

		pre_err_n = pre_err_q;
		if (in_frame && (idx_q == POS_PRE_TOGGLE)
				&& !in_window(dur_s1, cfg.preamble_min, cfg.preamble_max)) begin
			pre_err_n = 1'b1;
		end
		if (in_frame && (idx_q == POS_PRE_SPACE)
				&& !in_window(dur_s1, cfg.short_min, cfg.short_max)) begin
			pre_err_n = 1'b1;
		end

		tog_long_n = tog_long_q;
		if (data_pos && !odd) begin
			tog_long_n = in_window(dur_s1, cfg.long_min, cfg.long_max);
		end

		// Space pulses shift one bit into the channel, then the command field.
		chan_n = chan_q;
		cmd_n  = cmd_q;
		if (data_pos && odd) begin
			if (idx_q < CHAN_END) begin
				chan_n = {chan_q[FIELD_BITS-2:0], bit_val};
			end else begin
				cmd_n = {cmd_q[FIELD_BITS-2:0], bit_val};
			end
		end

		idx_n = (idx_q == IDX_MAX) ? idx_q : idx_q + IDX_W'(1);

		// First applicable reason wins.
		if (idx_n != FRAME_LEN) begin
			reason_n = ERR_LENGTH;
		end else if (kind_err_n) begin
			reason_n = ERR_KIND;
		end else if (pre_err_n) begin
			reason_n = ERR_PREAMBLE;
		end else if ((chan_n != cfg.chan_a) && (chan_n != cfg.chan_b)) begin
			reason_n = ERR_CHANNEL;
		end else begin
			reason_n = ERR_NONE;
		end
	end

	// Frame state update; the last pulse clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			kind_err_q <= 1'b0;
			pre_err_q  <= 1'b0;
			tog_long_q <= 1'b0;
			chan_q     <= '0;
			cmd_q      <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				idx_q      <= '0;
				kind_err_q <= 1'b0;
				pre_err_q  <= 1'b0;
				tog_long_q <= 1'b0;
				chan_q     <= '0;
				cmd_q      <= '0;
			end else begin
				idx_q      <= idx_n;
				kind_err_q <= kind_err_n;
				pre_err_q  <= pre_err_n;
				tog_long_q <= tog_long_n;
				chan_q     <= chan_n;
				cmd_q      <= cmd_n;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; fields are zero for a rejected frame.
	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			ok_q       <= (reason_n == ERR_NONE);
			chan_out_q <= (reason_n == ERR_NONE) ? chan_n : '0;
			cmd_out_q  <= (reason_n == ERR_NONE) ? cmd_n : '0;
			reason_q   <= reason_n;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frame_ok     = ok_q;
	assign result.channel_code = chan_out_q;
	assign result.command_code = cmd_out_q;
	assign result.error_reason = reason_q;

endmodule

// ===== sv/ir_pulse_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder
// Decodes infrared frames of eighteen toggle/space pulses into a channel
// and a command code, with a configurable set of duration windows.
//
// Usage:
// Pulses enter on the pulse channel (valid/ready), one transaction per
// pulse, with frame_end set on the last pulse of a frame. Only that pulse
// produces a transaction on the result channel: frame_ok, channel_code,
// command_code and error_reason. Other pulses produce nothing.
// Throughput is one pulse per cycle unless a frame end is held in the input
// register. A pulse is decoded from the input register; the last pulse of a
// frame then writes its result into the output register. When the receiver
// stalls, the result waits in the output register while further pulses are
// still accepted; only a second frame end backs up into the input register
// and then drops pulse.ready. Reset clears the frame state and both valid
// flags and loads the default windows and channel codes. Registers are
// written over the APB-style port at byte address 4 * index; the user must
// write them only while no frame is in flight, which the block does not check.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder
	import irpfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	irpfd_pulse_if.sink           pulse,
	irpfd_result_if.source        result
);

	cfg_t cfg;

	// Configuration registers.
	irpfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pulse decoder.
	irpfd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pulse  (pulse),
		.result (result)
	);

endmodule

// ===== test/ir_frame_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_frame_result_check
// Watches the pulse and result channels and the register port of the frame
// decoder, predicts the frame result of every pulse that ends a frame, and
// compares each result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module ir_frame_result_check
	import irpfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	irpfd_pulse_if                pulse,
	irpfd_result_if               result,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic                  frame_ok;
		logic [FIELD_BITS-1:0] channel_code;
		logic [FIELD_BITS-1:0] command_code;
		logic [REASON_W-1:0]   error_reason;
	} frame_result_t;

	// Mirror of the register file and of the frame being collected.
	cfg_t                  cfg;
	logic [IDX_W-1:0]      pos_count;
	logic                  kind_bad;
	logic                  preamble_bad;
	logic                  toggle_long;
	logic [FIELD_BITS-1:0] chan_bits;
	logic [FIELD_BITS-1:0] cmd_bits;
	frame_result_t         expected_frames [$];

	function automatic void clear_frame();
		pos_count    = '0;
		kind_bad     = 1'b0;
		preamble_bad = 1'b0;
		toggle_long  = 1'b0;
		chan_bits    = '0;
		cmd_bits     = '0;
	endfunction

	// Update the frame state with one pulse; a pulse that ends a frame
	// queues the result that the decoder has to produce for it.
	function automatic void decode_pulse(
		input logic [KIND_W-1:0] kind,
		input logic [DUR_W-1:0]  dur,
		input logic              last
	);
		logic          odd;
		logic          bit_val;
		frame_result_t res;
		if (pos_count < FRAME_LEN) begin
			odd = pos_count[0];
			if (kind != (odd ? KIND_SPACE : KIND_TOGGLE))
				kind_bad = 1'b1;
			if (pos_count == POS_PRE_TOGGLE) begin
				if (!(dur > cfg.preamble_min && dur < cfg.preamble_max))
					preamble_bad = 1'b1;
			end else if (pos_count == POS_PRE_SPACE) begin
				if (!(dur > cfg.short_min && dur < cfg.short_max))
					preamble_bad = 1'b1;
			end else if (!odd) begin
				toggle_long = (dur > cfg.long_min) && (dur < cfg.long_max);
			end else begin
				bit_val = toggle_long && (dur > cfg.short_min);
				if (pos_count < CHAN_END)
					chan_bits = {chan_bits[FIELD_BITS-2:0], bit_val};
				else
					cmd_bits = {cmd_bits[FIELD_BITS-2:0], bit_val};
			end
		end
		// The pulse count saturates, so very long frames still read as wrong length.
		if (pos_count != IDX_MAX)
			pos_count = pos_count + IDX_W'(1);
		if (last) begin
			res = '0;
			if (pos_count != FRAME_LEN)
				res.error_reason = ERR_LENGTH;
			else if (kind_bad)
				res.error_reason = ERR_KIND;
			else if (preamble_bad)
				res.error_reason = ERR_PREAMBLE;
			else if (chan_bits != cfg.chan_a && chan_bits != cfg.chan_b)
				res.error_reason = ERR_CHANNEL;
			else begin
				res.frame_ok     = 1'b1;
				res.channel_code = chan_bits;
				res.command_code = cmd_bits;
				res.error_reason = ERR_NONE;
			end
			expected_frames.push_back(res);
			clear_frame();
		end
	endfunction

	function automatic void check_field(
		input string                 name,
		input logic [FIELD_BITS-1:0] want,
		input logic [FIELD_BITS-1:0] got
	);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void mirror_write(
		input logic [2:0]            idx,
		input logic [APB_DATA_W-1:0] data
	);
		case (idx)
			REG_PREAMBLE_MIN: cfg.preamble_min = data[DUR_W-1:0];
			REG_PREAMBLE_MAX: cfg.preamble_max = data[DUR_W-1:0];
			REG_SHORT_MIN:    cfg.short_min    = data[DUR_W-1:0];
			REG_SHORT_MAX:    cfg.short_max    = data[DUR_W-1:0];
			REG_LONG_MIN:     cfg.long_min     = data[DUR_W-1:0];
			REG_LONG_MAX:     cfg.long_max     = data[DUR_W-1:0];
			REG_CHAN_A:       cfg.chan_a       = data[FIELD_BITS-1:0];
			REG_CHAN_B:       cfg.chan_b       = data[FIELD_BITS-1:0];
			default: ;
		endcase
	endfunction

	// Sample every channel at the rising edge; results are compared before
	// the pulse of the same edge is decoded.
	always @(posedge clk or negedge arst_n) begin : watch
		frame_result_t want;
		if (!arst_n) begin
			cfg.preamble_min = RST_PREAMBLE_MIN;
			cfg.preamble_max = RST_PREAMBLE_MAX;
			cfg.short_min    = RST_SHORT_MIN;
			cfg.short_max    = RST_SHORT_MAX;
			cfg.long_min     = RST_LONG_MIN;
			cfg.long_max     = RST_LONG_MAX;
			cfg.chan_a       = RST_CHAN_A;
			cfg.chan_b       = RST_CHAN_B;
			clear_frame();
			expected_frames.delete();
			fail_count = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_frames.size() == 0) begin
					$error("result transaction with no frame end waiting for it");
					fail_count++;
				end else begin
					want = expected_frames.pop_front();
					check_field("frame_ok", FIELD_BITS'(want.frame_ok),
						FIELD_BITS'(result.frame_ok));
					check_field("channel_code", want.channel_code, result.channel_code);
					check_field("command_code", want.command_code, result.command_code);
					check_field("error_reason", FIELD_BITS'(want.error_reason),
						FIELD_BITS'(result.error_reason));
				end
			end
			if (psel && penable && pwrite && pready)
				mirror_write(paddr[4:2], pwdata);
			if (pulse.valid && pulse.ready)
				decode_pulse(pulse.pulse_kind, pulse.pulse_duration, pulse.frame_end);
		end
		pending = expected_frames.size();
	end

endmodule

// ===== test/ir_pulse_frame_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder_test
// Drives pulse frames into the decoder under a series of register settings,
// with bursty pulse traffic and a stalling result receiver. The result
// checker beside the decoder predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder_test;
	import irpfd_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_PULSES  = 235;
	localparam int MAX_LEN       = 48;
	localparam int NUM_PHASES    = 8;

	// Pulse kinds that are neither toggle nor space.
	localparam logic [KIND_W-1:0] KIND_OTHER_LO = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OTHER_HI = 2'd3;

	typedef enum {
		STYLE_DEFAULT,
		STYLE_ORDERED,
		STYLE_ZERO,
		STYLE_ONES,
		STYLE_WIDE,
		STYLE_WILD
	} cfg_style_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	irpfd_pulse_if  pulse_ch ();
	irpfd_result_if result_ch ();

	int fail_count;
	int pending;
	int idle_cycles = 0;
	int burst_left  = 0;
	int pulses_sent = 0;

	// Settings currently loaded, used to aim durations at the windows.
	cfg_t cur_cfg;

	// Frame under construction.
	logic [KIND_W-1:0] frame_kind [0:MAX_LEN-1];
	logic [DUR_W-1:0]  frame_dur  [0:MAX_LEN-1];
	int                frame_len;

	ir_pulse_frame_decoder DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pulse   (pulse_ch),
		.result  (result_ch)
	);

	ir_frame_result_check result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pulse      (pulse_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Count cycles without any transaction on any port.
	always @(posedge clk) begin
		if ((pulse_ch.valid && pulse_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(psel && penable && pwrite && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= IDLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// The receiver picks a new stall pattern at the end of each randomly drawn span.
	initial begin : result_stall
		int mode;
		int span;
		int n;
		result_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(16, 96);
			for (n = 0; n < span; n++) begin
				@(negedge clk);
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 3) != 0);
					2: result_ch.ready <= ($urandom_range(0, 3) == 0);
					3: result_ch.ready <= ((n % 5) != 0);
					default: result_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [DUR_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {DUR_W'($urandom_range(0, 65535)), value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Load every register; the channel codes carry junk in their unused bits.
	task automatic write_config(input cfg_t c);
		cur_cfg = c;
		apb_write(REG_PREAMBLE_MIN, c.preamble_min);
		apb_write(REG_PREAMBLE_MAX, c.preamble_max);
		apb_write(REG_SHORT_MIN, c.short_min);
		apb_write(REG_SHORT_MAX, c.short_max);
		apb_write(REG_LONG_MIN, c.long_min);
		apb_write(REG_LONG_MAX, c.long_max);
		apb_write(REG_CHAN_A, {12'($urandom_range(0, 4095)), c.chan_a});
		apb_write(REG_CHAN_B, {12'($urandom_range(0, 4095)), c.chan_b});
	endtask

	function automatic cfg_t pick_config(input cfg_style_t style);
		cfg_t c;
		case (style)
			STYLE_ORDERED: begin
				c.preamble_min = DUR_W'($urandom_range(1000, 20000));
				c.preamble_max = c.preamble_min + DUR_W'($urandom_range(2, 3000));
				c.short_min    = DUR_W'($urandom_range(50, 800));
				c.short_max    = c.short_min + DUR_W'($urandom_range(2, 600));
				c.long_min     = c.short_max + DUR_W'($urandom_range(0, 2000));
				c.long_max     = c.long_min + DUR_W'($urandom_range(2, 800));
				c.chan_a       = FIELD_BITS'($urandom_range(0, 15));
				c.chan_b       = FIELD_BITS'($urandom_range(0, 15));
			end
			STYLE_ZERO: c = '0;
			STYLE_ONES: c = '1;
			STYLE_WIDE: begin
				c.preamble_min = '0;
				c.preamble_max = '1;
				c.short_min    = '0;
				c.short_max    = '1;
				c.long_min     = '0;
				c.long_max     = '1;
				c.chan_a       = '1;
				c.chan_b       = '0;
			end
			STYLE_WILD: begin
				c.preamble_min = DUR_W'($urandom_range(0, 65535));
				c.preamble_max = DUR_W'($urandom_range(0, 65535));
				c.short_min    = DUR_W'($urandom_range(0, 65535));
				c.short_max    = DUR_W'($urandom_range(0, 65535));
				c.long_min     = DUR_W'($urandom_range(0, 65535));
				c.long_max     = DUR_W'($urandom_range(0, 65535));
				c.chan_a       = FIELD_BITS'($urandom_range(0, 15));
				c.chan_b       = FIELD_BITS'($urandom_range(0, 15));
			end
			default: begin
				c.preamble_min = RST_PREAMBLE_MIN;
				c.preamble_max = RST_PREAMBLE_MAX;
				c.short_min    = RST_SHORT_MIN;
				c.short_max    = RST_SHORT_MAX;
				c.long_min     = RST_LONG_MIN;
				c.long_max     = RST_LONG_MAX;
				c.chan_a       = RST_CHAN_A;
				c.chan_b       = RST_CHAN_B;
			end
		endcase
		return c;
	endfunction

	// Durations outside the window: on or just past a bound, or at either end of the range.
	function automatic logic [DUR_W-1:0] dur_outside(input int lo, input int hi);
		case ($urandom_range(0, 5))
			0: return DUR_W'(lo);
			1: return DUR_W'(hi);
			2: return DUR_W'((lo > 0) ? lo - 1 : 0);
			3: return DUR_W'((hi < 65535) ? hi + 1 : 65535);
			4: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [DUR_W-1:0] dur_inside(input int lo, input int hi);
		if (hi - lo < 2)
			return dur_outside(lo, hi);
		case ($urandom_range(0, 3))
			0: return DUR_W'(lo + 1);
			1: return DUR_W'(hi - 1);
			default: return DUR_W'($urandom_range(lo + 1, hi - 1));
		endcase
	endfunction

	// A space that does or does not exceed the short minimum.
	function automatic logic [DUR_W-1:0] dur_space(input logic high);
		int smin;
		smin = cur_cfg.short_min;
		if (high) begin
			if (smin == 65535)
				return '1;
			return DUR_W'(($urandom_range(0, 3) == 0) ? smin + 1 : $urandom_range(smin + 1, 65535));
		end
		return DUR_W'(($urandom_range(0, 3) == 0) ? smin : $urandom_range(0, smin));
	endfunction

	// A well-formed frame with a random command, mostly on a known channel.
	function automatic void build_good_frame();
		logic [2*FIELD_BITS-1:0] code;
		int                      pick;
		int                      i;
		pick = $urandom_range(0, 4);
		code[7:4] = (pick < 2) ? cur_cfg.chan_a :
			(pick < 4) ? cur_cfg.chan_b : FIELD_BITS'($urandom_range(0, 15));
		code[3:0] = FIELD_BITS'($urandom_range(0, 15));
		frame_len = FRAME_PULSES;
		frame_kind[0] = KIND_TOGGLE;
		frame_dur[0]  = dur_inside(cur_cfg.preamble_min, cur_cfg.preamble_max);
		frame_kind[1] = KIND_SPACE;
		frame_dur[1]  = dur_inside(cur_cfg.short_min, cur_cfg.short_max);
		for (i = 0; i < 2 * FIELD_BITS; i++) begin
			frame_kind[2 + 2 * i] = KIND_TOGGLE;
			frame_kind[3 + 2 * i] = KIND_SPACE;
			if (code[7 - i]) begin
				frame_dur[2 + 2 * i] = dur_inside(cur_cfg.long_min, cur_cfg.long_max);
				frame_dur[3 + 2 * i] = dur_space(1'b1);
			end else if ($urandom_range(0, 1)) begin
				frame_dur[2 + 2 * i] = dur_outside(cur_cfg.long_min, cur_cfg.long_max);
				frame_dur[3 + 2 * i] = dur_space(1'($urandom_range(0, 1)));
			end else begin
				frame_dur[2 + 2 * i] = dur_inside(cur_cfg.long_min, cur_cfg.long_max);
				frame_dur[3 + 2 * i] = dur_space(1'b0);
			end
		end
	endfunction

	function automatic void fill_noise(input int first);
		int k;
		for (k = first; k < frame_len; k++) begin
			frame_kind[k] = KIND_W'($urandom_range(0, 3));
			frame_dur[k]  = DUR_W'($urandom_range(0, 65535));
		end
	endfunction

	// Present one pulse and wait for its transaction; the sender runs in
	// bursts with idle gaps in between.
	task automatic send_pulse(
		input logic [KIND_W-1:0] kind,
		input logic [DUR_W-1:0]  dur,
		input logic              last
	);
		@(negedge clk);
		if (burst_left == 0) begin
			pulse_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 30))
				@(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 24);
		end
		pulse_ch.valid          <= 1'b1;
		pulse_ch.pulse_kind     <= kind;
		pulse_ch.pulse_duration <= dur;
		pulse_ch.frame_end      <= last;
		@(posedge clk);
		while (!pulse_ch.ready)
			@(posedge clk);
		burst_left--;
		pulses_sent++;
	endtask

	task automatic send_frame();
		int k;
		for (k = 0; k < frame_len; k++)
			send_pulse(frame_kind[k], frame_dur[k], k == frame_len - 1);
	endtask

	task automatic pulse_idle();
		@(negedge clk);
		pulse_ch.valid <= 1'b0;
	endtask

	// Wait until every frame result has been taken and the pipeline is empty.
	task automatic drain_results();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// Mostly good frames; the rest are cut short, overlong, carry a wrong
	// kind or a bad preamble, or are pure noise.
	task automatic send_random_frame();
		int shape;
		int pos;
		shape = $urandom_range(0, 99);
		build_good_frame();
		if (shape >= 93) begin
			frame_len = $urandom_range(1, 24);
			fill_noise(0);
		end else if (shape >= 86) begin
			if ($urandom_range(0, 1))
				frame_dur[0] = dur_outside(cur_cfg.preamble_min, cur_cfg.preamble_max);
			else
				frame_dur[1] = dur_outside(cur_cfg.short_min, cur_cfg.short_max);
		end else if (shape >= 78) begin
			pos = $urandom_range(0, FRAME_PULSES - 1);
			frame_kind[pos] = KIND_W'(frame_kind[pos] + KIND_W'($urandom_range(1, 3)));
			if ($urandom_range(0, 1))
				frame_dur[0] = dur_outside(cur_cfg.preamble_min, cur_cfg.preamble_max);
		end else if (shape >= 70) begin
			frame_len = $urandom_range(FRAME_PULSES + 1, 40);
			fill_noise(FRAME_PULSES);
		end else if (shape >= 62) begin
			frame_len = $urandom_range(1, FRAME_PULSES - 1);
			if ($urandom_range(0, 1))
				frame_kind[0] = KIND_OTHER_HI;
		end
		send_frame();
	endtask

	// Field extremes and an accepted frame with every bit on a window bound.
	task automatic send_directed();
		logic [2*FIELD_BITS-1:0] code;
		int                      i;
		send_pulse(KIND_OTHER_HI, '1, 1'b1);
		code = {RST_CHAN_B, 4'b1011};
		frame_len = FRAME_PULSES;
		frame_kind[0] = KIND_TOGGLE;
		frame_dur[0]  = RST_PREAMBLE_MIN + 1'b1;
		frame_kind[1] = KIND_SPACE;
		frame_dur[1]  = RST_SHORT_MAX - 1'b1;
		for (i = 0; i < 2 * FIELD_BITS; i++) begin
			frame_kind[2 + 2 * i] = KIND_TOGGLE;
			frame_kind[3 + 2 * i] = KIND_SPACE;
			if (code[7 - i]) begin
				frame_dur[2 + 2 * i] = (i % 2) ? RST_LONG_MAX - 1'b1 : RST_LONG_MIN + 1'b1;
				frame_dur[3 + 2 * i] = (i % 2) ? '1 : RST_SHORT_MIN + 1'b1;
			end else begin
				frame_dur[2 + 2 * i] = (i % 2) ? RST_LONG_MIN : (RST_LONG_MIN + RST_LONG_MAX) / 2;
				frame_dur[3 + 2 * i] = (i % 2) ? RST_SHORT_MAX - 1'b1 : RST_SHORT_MIN;
			end
		end
		send_frame();
		send_pulse(KIND_OTHER_LO, '0, 1'b1);
	endtask

	initial begin : stimulus
		cfg_style_t plan [NUM_PHASES];
		int phase_start;
		bit paused;
		int p;
		plan = '{STYLE_DEFAULT, STYLE_ORDERED, STYLE_ZERO,
			STYLE_WIDE, STYLE_ONES, STYLE_ORDERED, STYLE_WILD, STYLE_DEFAULT};
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		pulse_ch.valid          = 1'b0;
		pulse_ch.pulse_kind     = KIND_TOGGLE;
		pulse_ch.pulse_duration = '0;
		pulse_ch.frame_end      = 1'b0;
		cur_cfg = pick_config(STYLE_DEFAULT);
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_directed();

		// Each phase runs under its own settings, with one full drain midway.
		for (p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				pulse_idle();
				drain_results();
				write_config(pick_config(plan[p]));
			end
			phase_start = pulses_sent;
			paused = 1'b0;
			while (pulses_sent - phase_start < PHASE_PULSES) begin
				if (!paused && pulses_sent - phase_start >= PHASE_PULSES / 2) begin
					pulse_idle();
					drain_results();
					paused = 1'b1;
				end
				send_random_frame();
			end
		end

		pulse_idle();
		drain_results();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
